[hw/rtl/ascon_aead128_engine_defines.svh]
// ----------------------------------------------------------------------------
// ascon engine assertion macros
// shared concurrent assertion wrappers, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef ASCON_AEAD128_ENGINE_DEFINES_SVH
`define ASCON_AEAD128_ENGINE_DEFINES_SVH

// property that holds at every clock edge out of reset
`define ASCON_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define ASCON_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASCON_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/ascon_pkg.sv]
// ----------------------------------------------------------------------------
// ascon package
// shared types, codes and helpers for the ascon-aead128 engine
// ----------------------------------------------------------------------------
package ascon_pkg;

  typedef logic [63:0]      lane_t;
  typedef logic [4:0][63:0] state_t;

  localparam lane_t       AeadIv    = 64'h0000_1000_808c_0001;
  localparam lane_t       DomainSep = 64'h8000_0000_0000_0000;
  localparam logic [4:0]  BlockBytes = 5'd16;
  localparam logic [3:0]  LastRound = 4'd11;
  localparam logic [3:0]  P8Start   = 4'd4;
  localparam logic [3:0]  P12Start  = 4'd0;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_AD    = 2'd1,
    OP_MSG   = 2'd2,
    OP_FINAL = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_BADTAG = 2'd1,
    STAT_ORDER  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_READY = 3'd1,
    PH_AD    = 3'd2,
    PH_MSG   = 3'd3,
    PH_DONE  = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_PERM = 2'd1,
    ST_EMIT = 2'd2
  } fsm_e;

  typedef enum logic [2:0] {
    POST_INIT   = 3'd0,
    POST_AD     = 3'd1,
    POST_AD_PAD = 3'd2,
    POST_MSG    = 3'd3,
    POST_FINAL  = 3'd4
  } post_e;

  typedef enum logic [2:0] {
    CFG_KEY_LOW   = 3'd0,
    CFG_KEY_HIGH  = 3'd1,
    CFG_MASK_LOW  = 3'd2,
    CFG_MASK_HIGH = 3'd3,
    CFG_DECRYPT   = 3'd4,
    CFG_MASK_EN   = 3'd5
  } cfg_idx_e;

  // low n bytes set, n in 0..8
  function automatic lane_t byte_mask(input logic [3:0] n);
    lane_t m;
    if (n >= 4'd8) begin
      m = '1;
    end else begin
      m = (lane_t'(1) << {n[2:0], 3'b000}) - lane_t'(1);
    end
    return m;
  endfunction

endpackage

[hw/rtl/ascon_if.sv]
// ----------------------------------------------------------------------------
// ascon channel interfaces
// valid/ready request channels for input items and results
// ----------------------------------------------------------------------------
interface ascon_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [63:0] data_low;
  logic [63:0] data_high;
  logic [4:0]  byte_count;
  logic        last_block;

  modport source (output valid, op, data_low, data_high, byte_count, last_block,
                  input ready);
  modport sink (input valid, op, data_low, data_high, byte_count, last_block,
                output ready);
endinterface

interface ascon_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_low;
  logic [63:0] out_high;
  logic [4:0]  out_count;
  logic [1:0]  status;

  modport source (output valid, out_low, out_high, out_count, status, input ready);
  modport sink (input valid, out_low, out_high, out_count, status, output ready);
endinterface

[hw/rtl/ascon_round.sv]
// ----------------------------------------------------------------------------
// ascon round
// one round of the ascon permutation, round index selects the constant
// ----------------------------------------------------------------------------
module ascon_round
  import ascon_pkg::*;
(
  input  state_t     x_i,
  input  logic [3:0] rnd_i,
  output state_t     x_o
);

  function automatic lane_t rotr(input lane_t v, input int unsigned s);
    return (v >> s) | (v << (64 - s));
  endfunction

  always_comb begin
    lane_t a0, a1, a2, a3, a4;
    lane_t t0, t1, t2, t3, t4;
    logic [7:0] rc;
    rc = {4'hf - rnd_i, rnd_i};
    a0 = x_i[0];
    a1 = x_i[1];
    a2 = x_i[2] ^ {56'h0, rc};
    a3 = x_i[3];
    a4 = x_i[4];
    // substitution layer
    a0 = a0 ^ a4; a4 = a4 ^ a3; a2 = a2 ^ a1;
    t0 = ~a0 & a1; t1 = ~a1 & a2; t2 = ~a2 & a3;
    t3 = ~a3 & a4; t4 = ~a4 & a0;
    a0 = a0 ^ t1; a1 = a1 ^ t2; a2 = a2 ^ t3; a3 = a3 ^ t4; a4 = a4 ^ t0;
    a1 = a1 ^ a0; a0 = a0 ^ a4; a3 = a3 ^ a2; a2 = ~a2;
    // linear layer
    x_o[0] = a0 ^ rotr(a0, 19) ^ rotr(a0, 28);
    x_o[1] = a1 ^ rotr(a1, 61) ^ rotr(a1, 39);
    x_o[2] = a2 ^ rotr(a2, 1)  ^ rotr(a2, 6);
    x_o[3] = a3 ^ rotr(a3, 10) ^ rotr(a3, 17);
    x_o[4] = a4 ^ rotr(a4, 7)  ^ rotr(a4, 41);
  end

endmodule

[hw/rtl/ascon_aead128_engine.sv]
// flow: a request is taken in idle, its permutation rounds run on the round unit, and
//   the result is then posted; a full last ad block runs a second permutation for the
//   padded empty block, while partial payload blocks and rejected requests skip it
// throughput: one request at a time; the single shared round unit sets the pace
// reset: asynchronous active low, clears config, lanes, phase and output valid
// ----------------------------------------------------------------------------
// ascon-aead128 engine
// sequencer around one shared ascon round unit, 16-byte blocks per request
// ----------------------------------------------------------------------------
`include "ascon_aead128_engine_defines.svh"

module ascon_aead128_engine
  import ascon_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  ascon_in_if.sink    in_i,
  ascon_out_if.source out_o
);

  // configuration registers
  lane_t key_lo_q, key_hi_q, mask_lo_q, mask_hi_q;
  logic  decrypt_q, mask_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lo_q  <= '0;
      key_hi_q  <= '0;
      mask_lo_q <= '0;
      mask_hi_q <= '0;
      decrypt_q <= 1'b0;
      mask_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_KEY_LOW:   key_lo_q  <= cfg_wdata_i;
        CFG_KEY_HIGH:  key_hi_q  <= cfg_wdata_i;
        CFG_MASK_LOW:  mask_lo_q <= cfg_wdata_i;
        CFG_MASK_HIGH: mask_hi_q <= cfg_wdata_i;
        CFG_DECRYPT:   decrypt_q <= cfg_wdata_i[0];
        CFG_MASK_EN:   mask_en_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // engine state
  fsm_e       state_q, state_d;
  phase_e     phase_q, phase_d;
  post_e      post_q, post_d;
  logic [3:0] rnd_q, rnd_d;
  state_t     x_q, x_d, x_rnd;
  logic       last_q, last_d;
  lane_t      tag_lo_q, tag_lo_d, tag_hi_q, tag_hi_d;

  // pending result, then the output register
  lane_t      res_lo_q, res_lo_d, res_hi_q, res_hi_d;
  logic [4:0] res_cnt_q, res_cnt_d;
  status_e    res_st_q, res_st_d;
  logic       out_valid_q, out_valid_d;
  lane_t      out_lo_q, out_lo_d, out_hi_q, out_hi_d;
  logic [4:0] out_cnt_q, out_cnt_d;
  status_e    out_st_q, out_st_d;

  // the shared round unit
  ascon_round u_round (
    .x_i   (x_q),
    .rnd_i (rnd_q),
    .x_o   (x_rnd)
  );

  // request fields
  op_e        op;
  lane_t      dl, dh, ml, mh, pad_lo, pad_hi;
  logic [4:0] n;
  logic       last;

  assign op   = op_e'(in_i.op);
  assign dl   = in_i.data_low;
  assign dh   = in_i.data_high;
  assign n    = in_i.byte_count;
  assign last = in_i.last_block;
  assign ml   = byte_mask((n >= 5'd8) ? 4'd8 : n[3:0]);
  assign mh   = (n > 5'd8) ? byte_mask(4'(n - 5'd8)) : '0;
  // padding byte at rate position n, none for a full block
  assign pad_lo = (n < 5'd8) ? (lane_t'(1) << {n[2:0], 3'b000}) : '0;
  assign pad_hi = (n >= 5'd8 && n < BlockBytes) ? (lane_t'(1) << {n[2:0], 3'b000}) : '0;

  assign in_i.ready = (state_q == ST_IDLE);

  always_comb begin
    lane_t nl, nh, x0n, x1n, x4n;
    state_d     = state_q;
    phase_d     = phase_q;
    post_d      = post_q;
    rnd_d       = rnd_q;
    x_d         = x_q;
    last_d      = last_q;
    tag_lo_d    = tag_lo_q;
    tag_hi_d    = tag_hi_q;
    res_lo_d    = res_lo_q;
    res_hi_d    = res_hi_q;
    res_cnt_d   = res_cnt_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_lo_d    = out_lo_q;
    out_hi_d    = out_hi_q;
    out_cnt_d   = out_cnt_q;
    out_st_d    = out_st_q;
    nl  = dl ^ (mask_en_q ? mask_lo_q : '0);
    nh  = dh ^ (mask_en_q ? mask_hi_q : '0);
    x4n = x_q[4] ^ ((phase_q == PH_READY) ? DomainSep : '0);
    x0n = decrypt_q ? ((x_q[0] & ~ml) | (dl & ml)) : (x_q[0] ^ (dl & ml));
    x1n = decrypt_q ? ((x_q[1] & ~mh) | (dh & mh)) : (x_q[1] ^ (dh & mh));

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          last_d    = last;
          tag_lo_d  = dl;
          tag_hi_d  = dh;
          res_lo_d  = '0;
          res_hi_d  = '0;
          res_cnt_d = '0;
          res_st_d  = STAT_OK;
          state_d   = ST_EMIT;
          if (n > BlockBytes) begin
            res_st_d = STAT_ORDER;
          end else begin
            case (op)
              OP_INIT: begin
                x_d     = {nh, nl, key_hi_q, key_lo_q, AeadIv};
                rnd_d   = P12Start;
                post_d  = POST_INIT;
                phase_d = PH_READY;
                state_d = ST_PERM;
              end
              OP_AD: begin
                if (!(phase_q == PH_READY || phase_q == PH_AD) ||
                    (!last && n != BlockBytes)) begin
                  res_st_d = STAT_ORDER;
                end else if (last && n == 5'd0 && phase_q == PH_READY) begin
                  // empty associated data: only domain separation
                  x_d[4]  = x_q[4] ^ DomainSep;
                  phase_d = PH_MSG;
                end else begin
                  x_d[0] = x_q[0] ^ (dl & ml) ^ pad_lo;
                  x_d[1] = x_q[1] ^ (dh & mh) ^ pad_hi;
                  rnd_d  = P8Start;
                  post_d = (n == BlockBytes && last) ? POST_AD_PAD : POST_AD;
                  phase_d = last ? PH_MSG : PH_AD;
                  state_d = ST_PERM;
                end
              end
              OP_MSG: begin
                if (!(phase_q == PH_READY || phase_q == PH_MSG) ||
                    (!last && n != BlockBytes)) begin
                  res_st_d = STAT_ORDER;
                end else begin
                  res_lo_d  = decrypt_q ? ((x_q[0] ^ dl) & ml) : (x0n & ml);
                  res_hi_d  = decrypt_q ? ((x_q[1] ^ dh) & mh) : (x1n & mh);
                  res_cnt_d = n;
                  x_d[4]    = x4n;
                  phase_d   = last ? PH_DONE : PH_MSG;
                  if (n == BlockBytes) begin
                    x_d[0]  = x0n;
                    x_d[1]  = x1n;
                    rnd_d   = P8Start;
                    post_d  = POST_MSG;
                    state_d = ST_PERM;
                  end else begin
                    x_d[0] = x0n ^ pad_lo;
                    x_d[1] = x1n ^ pad_hi;
                  end
                end
              end
              OP_FINAL: begin
                if (phase_q != PH_DONE) begin
                  res_st_d = STAT_ORDER;
                end else begin
                  x_d[2]  = x_q[2] ^ key_lo_q;
                  x_d[3]  = x_q[3] ^ key_hi_q;
                  rnd_d   = P12Start;
                  post_d  = POST_FINAL;
                  phase_d = PH_IDLE;
                  state_d = ST_PERM;
                end
              end
              default: ;
            endcase
          end
        end
      end

      ST_PERM: begin
        x_d   = x_rnd;
        rnd_d = rnd_q + 4'd1;
        if (rnd_q == LastRound) begin
          state_d = ST_EMIT;
          case (post_q)
            POST_INIT: begin
              x_d[3] = x_rnd[3] ^ key_lo_q;
              x_d[4] = x_rnd[4] ^ key_hi_q;
            end
            POST_AD: begin
              if (last_q) x_d[4] = x_rnd[4] ^ DomainSep;
            end
            POST_AD_PAD: begin
              // full last ad block: absorb an empty padded block
              x_d[0]  = x_rnd[0] ^ lane_t'(1);
              rnd_d   = P8Start;
              post_d  = POST_AD;
              state_d = ST_PERM;
            end
            POST_MSG: begin
              if (last_q) x_d[0] = x_rnd[0] ^ lane_t'(1);
            end
            POST_FINAL: begin
              x_d[3] = x_rnd[3] ^ key_lo_q;
              x_d[4] = x_rnd[4] ^ key_hi_q;
              if (decrypt_q) begin
                res_st_d = ((x_d[3] != tag_lo_q) || (x_d[4] != tag_hi_q)) ?
                           STAT_BADTAG : STAT_OK;
              end else begin
                res_lo_d  = x_d[3];
                res_hi_d  = x_d[4];
                res_cnt_d = BlockBytes;
              end
            end
            default: ;
          endcase
        end
      end

      ST_EMIT: begin
        // move the result into the output register once it is free
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_lo_d    = res_lo_q;
          out_hi_d    = res_hi_q;
          out_cnt_d   = res_cnt_q;
          out_st_d    = res_st_q;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_IDLE;
      post_q      <= POST_INIT;
      rnd_q       <= '0;
      x_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      post_q      <= post_d;
      rnd_q       <= rnd_d;
      x_q         <= x_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    last_q    <= last_d;
    tag_lo_q  <= tag_lo_d;
    tag_hi_q  <= tag_hi_d;
    res_lo_q  <= res_lo_d;
    res_hi_q  <= res_hi_d;
    res_cnt_q <= res_cnt_d;
    res_st_q  <= res_st_d;
    out_lo_q  <= out_lo_d;
    out_hi_q  <= out_hi_d;
    out_cnt_q <= out_cnt_d;
    out_st_q  <= out_st_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_low   = out_lo_q;
  assign out_o.out_high  = out_hi_q;
  assign out_o.out_count = out_cnt_q;
  assign out_o.status    = out_st_q;

  `ASCON_ASSERT_NXT(a_accept_leaves_idle, in_i.valid && in_i.ready, state_q != ST_IDLE, "accepted request did not start work")
  `ASCON_ASSERT_IMP(a_round_in_range, state_q == ST_PERM, rnd_q <= LastRound, "round index past last round")
  `ASCON_ASSERT_IMP(a_result_from_emit, $rose(out_valid_q), $past(state_q) == ST_EMIT, "result posted outside emit")
  `ASCON_ASSERT_IMP(a_badtag_no_data, out_valid_q && out_st_q == STAT_BADTAG, out_cnt_q == 5'd0 && out_lo_q == '0, "tag mismatch carries data")

endmodule
